FILE: hw/rtl/tfm_pkg.sv
// ----------------------------------------------------------------------------
// tfm_pkg
// types, constants and row helpers shared by the tile flip matcher
// ----------------------------------------------------------------------------
package tfm_pkg;

  localparam int unsigned RowW    = 32;
  localparam int unsigned RefW    = 64;
  localparam int unsigned NumRefs = 4;
  localparam int unsigned RowIdxW = 3;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [RowW-1:0]    row_t;
  typedef logic [RefW-1:0]    ref_t;
  typedef logic [RowIdxW-1:0] row_idx_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // one flag per orientation, bit k set while orientation k still matches
  typedef struct packed {
    logic vert;
    logic both;
    logic horiz;
    logic plain;
  } flags_t;

  typedef enum logic [1:0] {
    ORIENT_PLAIN = 2'd0,
    ORIENT_HORIZ = 2'd1,
    ORIENT_BOTH  = 2'd2,
    ORIENT_VERT  = 2'd3
  } orient_t;

  localparam row_t     NIB_HI    = 32'hF0F0_F0F0;
  localparam row_t     NIB_LO    = 32'h0F0F_0F0F;
  localparam row_idx_t LAST_ROW  = 3'd7;
  localparam flags_t   FLAGS_ALL = 4'hF;

  // swap nibbles in every byte, then reverse the byte order
  function automatic row_t mirror_row(input row_t a);
    row_t b;
    b = ((a & NIB_HI) >> 4) | ((a & NIB_LO) << 4);
    return {b[7:0], b[15:8], b[23:16], b[31:24]};
  endfunction

endpackage

FILE: hw/rtl/tfm_if.sv
// ----------------------------------------------------------------------------
// tfm_row_if / tfm_res_if
// valid/ready channels for candidate rows and match results
// ----------------------------------------------------------------------------
interface tfm_row_if;
  logic          valid;
  logic          ready;
  tfm_pkg::row_t row_data;

  modport source (output valid, output row_data, input ready);
  modport sink   (input valid, input row_data, output ready);
endinterface

interface tfm_res_if;
  logic       valid;
  logic       ready;
  logic       is_match;
  logic [1:0] orientation;

  modport source (output valid, output is_match, output orientation, input ready);
  modport sink   (input valid, input is_match, input orientation, output ready);
endinterface

FILE: hw/rtl/tile_flip_matcher_4bpp_top.sv
// ----------------------------------------------------------------------------
// tile_flip_matcher_4bpp_top
// matches an 8x8 4bpp candidate tile against a reference in four orientations
//
// in_row carries one 32-bit candidate row per word, top row first, leftmost
// byte in bits 7:0. every eighth accepted word ends a tile and produces one
// word on out_res: is_match and the first matching orientation (0 plain,
// 1 horizontal, 2 both, 3 vertical; 0 when nothing matches).
// the reference tile is loaded through cfg_we/cfg_index/cfg_wdata, four
// 64-bit registers; the user must load it only while no tile is in progress
// (not enforced). each row is compared as it is accepted, one per cycle
// unless the last row waits; the result shows the cycle after row 7 is taken.
// the result sits in an output register; while the receiver stalls, rows
// 0 to 6 of the next tile are still taken, only the last row waits.
// reset (rst_n low, synchronous) clears the reference registers, the row
// count and the output valid flag, and sets all orientation flags.
// ----------------------------------------------------------------------------
module tile_flip_matcher_4bpp_top (
  input  logic                      clk,
  input  logic                      rst_n,
  tfm_row_if.sink                   in_row,
  tfm_res_if.source                 out_res,
  input  logic                      cfg_we,
  input  tfm_pkg::cfg_idx_t         cfg_index,
  input  tfm_pkg::ref_t             cfg_wdata
);

  tfm_pkg::ref_t     ref_r [tfm_pkg::NumRefs];
  tfm_pkg::row_idx_t row_idx_r, row_idx_nxt, opp_idx;
  tfm_pkg::flags_t   flags_r, flags_nxt, keep, fin;
  logic              out_valid_r, out_valid_nxt;
  logic              out_match_r;
  tfm_pkg::orient_t  out_orient_r, orient_sel;
  tfm_pkg::row_t     same_row, opp_row;
  logic              accept, last_row;

  assign opp_idx  = ~row_idx_r;
  assign same_row = ref_r[row_idx_r[2:1]][row_idx_r[0]*tfm_pkg::RowW +: tfm_pkg::RowW];
  assign opp_row  = ref_r[opp_idx[2:1]][opp_idx[0]*tfm_pkg::RowW +: tfm_pkg::RowW];

  tfm_row_cmp u_cmp (
    .row      (in_row.row_data),
    .same_row (same_row),
    .opp_row  (opp_row),
    .keep     (keep)
  );

  assign last_row     = (row_idx_r == tfm_pkg::LAST_ROW);
  assign in_row.ready = !last_row || !out_valid_r || out_res.ready;
  assign accept       = in_row.valid && in_row.ready;
  assign fin          = flags_r & keep;

  always_comb begin
    if (fin.plain)      orient_sel = tfm_pkg::ORIENT_PLAIN;
    else if (fin.horiz) orient_sel = tfm_pkg::ORIENT_HORIZ;
    else if (fin.both)  orient_sel = tfm_pkg::ORIENT_BOTH;
    else if (fin.vert)  orient_sel = tfm_pkg::ORIENT_VERT;
    else                orient_sel = tfm_pkg::ORIENT_PLAIN;
  end

  always_comb begin
    row_idx_nxt   = row_idx_r;
    flags_nxt     = flags_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    if (accept) begin
      row_idx_nxt = row_idx_r + tfm_pkg::row_idx_t'(1);
      if (last_row) begin
        flags_nxt     = tfm_pkg::FLAGS_ALL;
        out_valid_nxt = 1'b1;
      end else begin
        flags_nxt = fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_idx_r   <= '0;
      flags_r     <= tfm_pkg::FLAGS_ALL;
      out_valid_r <= 1'b0;
    end else begin
      row_idx_r   <= row_idx_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && last_row) begin
      out_match_r  <= (fin != '0);
      out_orient_r <= orient_sel;
    end
  end

  // reference registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '{default: '0};
    end else if (cfg_we) begin
      ref_r[cfg_index] <= cfg_wdata;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.is_match    = out_match_r;
  assign out_res.orientation = out_orient_r;

endmodule

FILE: hw/rtl/tfm_row_cmp.sv
// ----------------------------------------------------------------------------
// tfm_row_cmp
// compares one candidate row against its own and its opposite reference row
// ----------------------------------------------------------------------------
module tfm_row_cmp (
  input  tfm_pkg::row_t   row,
  input  tfm_pkg::row_t   same_row,
  input  tfm_pkg::row_t   opp_row,
  output tfm_pkg::flags_t keep
);

  tfm_pkg::row_t mir;

  assign mir = tfm_pkg::mirror_row(row);

  assign keep.plain = (row == same_row);
  assign keep.horiz = (mir == same_row);
  assign keep.both  = (mir == opp_row);
  assign keep.vert  = (row == opp_row);

endmodule
